// File: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // Saturation limit for the data byte count of one transfer
    localparam logic [7:0] MAX_BYTES = 8'd128;

    // Width of the per-transfer event counter (reaches count + 3)
    localparam int PROG_W = 9;

    // Configuration port index width
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_START_WR  = 2'd0,
        OP_START_RD  = 2'd1,
        OP_BYTE_DONE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR = 2'd0,
        CFG_SUB_ADDR   = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_ARB  = 2'd1,
        ERR_NAK  = 2'd2,
        ERR_BOTH = 2'd3
    } err_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_count;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       arb_lost;
        logic       no_ack;
    } in_item_t;

    typedef struct packed {
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic       repeat_start;
        logic       enter_receive;
        logic       set_nak;
        logic       gen_stop;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       tx_taken;
        logic [1:0] error_code;
        logic       busy_res;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/i2c_master_byte_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_top
// I2C master transfer sequencer: one event beat in, one result beat out.
// ----------------------------------------------------------------------------
// Pipeline: the input beat is held in the input register, then the result
//   is registered in the result register.
// Throughput: one beat per cycle unless out_stall holds a result; the
//   transfer state is stepped inside i2cms_seq, so events go back to back.
// Reset: rst_n asynchronous, active low; clears transfer state, both config
//   registers and the valid flags of the two pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_sequencer_top (
    input  wire                            clk,
    input  wire                            rst_n,
    // event channel
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire i2cms_pkg::in_item_t       in_data,
    // result channel
    output logic                           out_valid,
    input  wire                            out_stall,
    output i2cms_pkg::out_item_t           out_data,
    // config write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [7:0]                      cfg_data
);
    import i2cms_pkg::*;

    // input register
    logic      in_vld_reg;
    in_item_t  in_item_reg;

    // result register
    logic      out_vld_reg;
    out_item_t out_item_reg;

    logic      advance;   // result register free or draining this cycle
    logic      step;      // buffered beat moves through the sequencer
    out_item_t res;

    assign advance   = !out_vld_reg || !out_stall;
    assign step      = in_vld_reg && advance;

    // the input register is full and cannot move on
    assign in_stall  = in_vld_reg && !advance;

    // config is always taken; writes happen only while idle is a rule for the user, not enforced here
    assign cfg_ready = 1'b1;

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_item_reg <= in_data;
    end

    i2cms_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (in_item_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= res;
    end

    // back-pressure only ever comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked result");

    // every stepped beat lands in the result register
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_vld_reg)
        else $error("stepped beat lost");

    // a held result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |=> $stable(out_item_reg))
        else $error("held result changed");

endmodule

`default_nettype wire

// File: rtl/i2cms_seq.sv
// ----------------------------------------------------------------------------
// i2cms_seq
// Transfer state, config registers and the combinational step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_seq (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [7:0]                    cfg_data,
    input  wire                          step,
    input  wire i2cms_pkg::in_item_t     item,
    output i2cms_pkg::out_item_t         res
);
    import i2cms_pkg::*;

    logic [6:0]        slave_addr_reg;
    logic [7:0]        sub_addr_reg;
    logic              active_reg,   active_next;
    logic              is_write_reg, is_write_next;
    logic [PROG_W-1:0] progress_reg, progress_next;
    logic [7:0]        total_reg,    total_next;

    logic [PROG_W-1:0] n_ext;
    logic [7:0]        cnt_sat;

    assign n_ext   = {{(PROG_W-8){1'b0}}, total_reg};
    assign cnt_sat = (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= '0;
            sub_addr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[6:0];
                CFG_SUB_ADDR:   sub_addr_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        res           = '0;
        active_next   = active_reg;
        is_write_next = is_write_reg;
        progress_next = progress_reg;
        total_next    = total_reg;

        unique case (item.opcode)
            OP_START_WR, OP_START_RD:
            begin
                active_next     = 1'b1;
                is_write_next   = (item.opcode == OP_START_WR);
                progress_next   = '0;
                total_next      = cnt_sat;
                res.drive_valid = 1'b1;
                res.drive_byte  = {slave_addr_reg, 1'b0};
            end
            OP_BYTE_DONE:
            begin
                if (active_reg)
                begin
                    res.error_code = {item.no_ack, item.arb_lost};
                    priority if (item.arb_lost)
                    begin
                        res.gen_stop = 1'b1;
                        active_next  = 1'b0;
                    end
                    else if (item.no_ack && !is_write_reg
                             && progress_reg == n_ext + PROG_W'(3))
                    begin
                        // NAK after the final read byte: stop, nothing stored
                        res.gen_stop = 1'b1;
                        active_next  = 1'b0;
                    end
                    else if (is_write_reg)
                    begin
                        priority if (progress_reg == '0)
                        begin
                            res.drive_valid = 1'b1;
                            res.drive_byte  = sub_addr_reg;
                        end
                        else if (progress_reg == n_ext + PROG_W'(1))
                        begin
                            res.gen_stop = 1'b1;
                            active_next  = 1'b0;
                        end
                        else
                        begin
                            res.drive_valid = 1'b1;
                            res.drive_byte  = item.tx_byte;
                            res.tx_taken    = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if (progress_reg == '0)
                        begin
                            res.drive_valid = 1'b1;
                            res.drive_byte  = sub_addr_reg;
                        end
                        else if (progress_reg == PROG_W'(1))
                        begin
                            res.repeat_start = 1'b1;
                            res.drive_valid  = 1'b1;
                            res.drive_byte   = {slave_addr_reg, 1'b1};
                        end
                        else if (progress_reg == PROG_W'(2))
                        begin
                            res.enter_receive = 1'b1;
                        end
                        else
                        begin
                            if (progress_reg == n_ext + PROG_W'(3))
                            begin
                                res.gen_stop = 1'b1;
                                active_next  = 1'b0;
                            end
                            else if (progress_reg == n_ext + PROG_W'(2))
                            begin
                                res.set_nak = 1'b1;
                            end
                            res.rx_valid = 1'b1;
                            res.rx_data  = item.rx_byte;
                        end
                    end
                    if (active_next)
                        progress_next = progress_reg + PROG_W'(1);
                end
            end
            default: ;
        endcase

        res.busy_res = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            is_write_reg <= 1'b0;
            progress_reg <= '0;
            total_reg    <= '0;
        end
        else if (step)
        begin
            active_reg   <= active_next;
            is_write_reg <= is_write_next;
            progress_reg <= progress_next;
            total_reg    <= total_next;
        end
    end

    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.gen_stop |=> !active_reg)
        else $error("transfer still active after stop");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.opcode == OP_START_WR || item.opcode == OP_START_RD)
        |=> active_reg && progress_reg == '0)
        else $error("start did not open a fresh transfer");

    a_rx_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        res.rx_valid |-> !is_write_reg && active_reg)
        else $error("byte stored outside a read");

    a_tx_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        res.tx_taken |-> is_write_reg && active_reg)
        else $error("tx byte taken outside a write");

endmodule

`default_nettype wire
